>>> sv/sbi_pkg.sv
// ----------------------------------------------------------------------------
// sbi_pkg
// Types and constants shared by the strip blur and inject block.
// ----------------------------------------------------------------------------
package sbi_pkg;

    localparam int IDX_W      = 6;
    localparam int LEVEL_W    = 16;
    localparam int PIPE_DEPTH = 11;

    localparam logic [16:0] DT_MAX      = 17'd100000;
    localparam logic [17:0] RATE_OFFSET = 18'd1311;
    localparam logic [17:0] HALF_Q16    = 18'd32768;
    localparam logic [23:0] FADE_DIV    = 24'd10000000;

    // blur divisor 2^23 * 15625, fade divisor 2^7 * 78125
    localparam logic [36:0] BLUR_HALF = 37'd65536000000;
    localparam logic [22:0] FADE_HALF = 23'd5000000;
    localparam logic [13:0] BLUR_ODD  = 14'd15625;
    localparam logic [16:0] FADE_ODD  = 17'd78125;
    localparam logic [21:0] BLUR_RECIP = 22'd2199023;
    localparam logic [19:0] FADE_RECIP = 20'd879609;

    localparam logic [2:0] MODE_PLAIN = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_END   = 3'd2;
    localparam logic [2:0] MODE_MID   = 3'd3;
    localparam logic [2:0] MODE_BOTH  = 3'd4;

    localparam logic [1:0] REG_BLUR_MODE    = 2'd0;
    localparam logic [1:0] REG_STRIP_LENGTH = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_SETUP,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic               valid;
        logic               emit;
        logic               last;
        logic               inj;
        logic               keep;
        logic [IDX_W-1:0]   idx;
        logic [LEVEL_W-1:0] centre;
    } pix_tag_t;

endpackage

>>> sv/sbi_cell.sv
// ----------------------------------------------------------------------------
// sbi_cell
// One pixel level of the strip; takes its neighbour's level on each shift.
// ----------------------------------------------------------------------------
module sbi_cell (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        shift_en,
    input  logic [15:0] level_in,
    output logic [15:0] level_out
);
    import sbi_pkg::*;

    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;

    always_comb begin
        level_next = shift_en ? level_in : level_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
        end else begin
            level_reg <= level_next;
        end
    end

    assign level_out = level_reg;

endmodule

>>> sv/sbi_pipe.sv
// ----------------------------------------------------------------------------
// sbi_pipe
// Per-pixel blur, fade, clamp and inject, eleven registered stages.
// ----------------------------------------------------------------------------
module sbi_pipe (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  sbi_pkg::pix_tag_t tag_in,
    input  logic [15:0]       left,
    input  logic [15:0]       right,
    input  logic [38:0]       k_factor,
    input  logic [23:0]       fade_factor,
    input  logic [15:0]       inject_level,
    output sbi_pkg::pix_tag_t tag_out,
    output logic [15:0]       level_out
);
    import sbi_pkg::*;

    pix_tag_t tag_reg [1:PIPE_DEPTH];

    logic signed [18:0] diff;
    logic [16:0] dmag1_reg;
    logic        neg_reg [1:5];
    logic [36:0] plo2_reg;
    logic [35:0] phi2_reg;
    logic [56:0] mag3;
    logic [33:0] t3_reg, t4_reg;
    logic [46:0] est_prod;
    logic [20:0] est4_reg, est5_reg;
    logic [34:0] rem5;
    logic [16:0] r5_reg;
    logic [20:0] q6;
    logic signed [22:0] v6_reg;
    logic        vneg_reg [7:10];
    logic [43:0] prod7_reg;
    logic [44:0] sum8;
    logic [37:0] t8_reg, t9_reg;
    logic [47:0] est2_prod;
    logic [21:0] est9_reg, est10_reg;
    logic [38:0] rem10;
    logic [17:0] r10_reg;
    logic [21:0] w11;
    logic [15:0] level11_reg;

    always_comb begin
        diff = $signed({3'b000, left}) + $signed({3'b000, right})
             - $signed({2'b00, tag_in.centre, 1'b0});
        mag3 = 57'(plo2_reg) + {1'b0, phi2_reg, 20'd0} + 57'(BLUR_HALF);
        est_prod = 47'(t3_reg[33:9]) * 47'(BLUR_RECIP);
        rem5 = 35'(t4_reg) - 35'(est4_reg) * 35'(BLUR_ODD);
        q6 = est5_reg;
        if (r5_reg >= 17'(2 * BLUR_ODD)) begin
            q6 = est5_reg + 21'd2;
        end else if (r5_reg >= 17'(BLUR_ODD)) begin
            q6 = est5_reg + 21'd1;
        end
        sum8 = 45'(prod7_reg) + 45'(FADE_HALF);
        est2_prod = 48'(t8_reg[37:10]) * 48'(FADE_RECIP);
        rem10 = 39'(t9_reg) - 39'(est9_reg) * 39'(FADE_ODD);
        w11 = est10_reg;
        if (r10_reg >= 18'(2 * FADE_ODD)) begin
            w11 = est10_reg + 22'd2;
        end else if (r10_reg >= 18'(FADE_ODD)) begin
            w11 = est10_reg + 22'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= PIPE_DEPTH; i++) begin
                tag_reg[i] <= '0;
            end
        end else if (en) begin
            tag_reg[1] <= tag_in;
            for (int i = 2; i <= PIPE_DEPTH; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg[1]  <= diff[18];
            dmag1_reg   <= diff[18] ? 17'(-diff) : diff[16:0];
            for (int i = 2; i <= 5; i++) begin
                neg_reg[i] <= neg_reg[i-1];
            end
            plo2_reg    <= 37'(dmag1_reg) * 37'(k_factor[19:0]);
            phi2_reg    <= 36'(dmag1_reg) * 36'(k_factor[38:20]);
            t3_reg      <= mag3[56:23];
            t4_reg      <= t3_reg;
            est4_reg    <= est_prod[46:26];
            est5_reg    <= est4_reg;
            r5_reg      <= rem5[16:0];
            v6_reg      <= neg_reg[5]
                ? $signed({7'd0, tag_reg[5].centre}) - $signed({2'b00, q6})
                : $signed({7'd0, tag_reg[5].centre}) + $signed({2'b00, q6});
            vneg_reg[7] <= v6_reg[22];
            prod7_reg   <= 44'(v6_reg[22] ? 20'(-v6_reg) : v6_reg[19:0])
                         * 44'(fade_factor);
            for (int i = 8; i <= 10; i++) begin
                vneg_reg[i] <= vneg_reg[i-1];
            end
            t8_reg      <= 38'(sum8[44:7]);
            t9_reg      <= t8_reg;
            est9_reg    <= est2_prod[47:26];
            est10_reg   <= est9_reg;
            r10_reg     <= rem10[17:0];
            if (tag_reg[10].keep) begin
                level11_reg <= tag_reg[10].centre;
            end else if (tag_reg[10].inj) begin
                level11_reg <= inject_level;
            end else if (vneg_reg[10]) begin
                level11_reg <= '0;
            end else if (w11 > 22'd65535) begin
                level11_reg <= 16'hFFFF;
            end else begin
                level11_reg <= w11[15:0];
            end
        end
    end

    assign tag_out   = tag_reg[PIPE_DEPTH];
    assign level_out = level11_reg;

endmodule

>>> sv/strip_blur_inject_unit.sv
// ----------------------------------------------------------------------------
// strip_blur_inject_unit
// Strip of pixel levels blurred, faded and injected once per frame tick.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one beat is a frame tick (inject level, blur amount, elapsed
//   microseconds). m_ channel: one beat per pixel in use, index order, tlast
//   on the final pixel. cfg_wen/cfg_addr/cfg_wdata set blur mode and strip
//   length between frames.
// frame processing
//   the levels sit in a ring of MAX_PIXELS cells that shifts once a cycle
//   while running and not stalled; each level passes an 11-stage arithmetic
//   pipe and comes back at the tail. a frame goes through the PREP and SETUP
//   states, then RUN until every level is back. one tick is worked on at a
//   time: s_tready is low during a frame.
// reset
//   all levels clear to zero, blur mode 0, strip length 64.
// stall
//   while m_tvalid is high and m_tready low, ring and pipe hold still.
// ----------------------------------------------------------------------------
module strip_blur_inject_unit #(
    parameter int MAX_PIXELS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // inject_level, blur_amount, elapsed_us
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // pixel_index, pixel_level
    output logic        m_tlast,
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_addr,
    input  logic [6:0]  cfg_wdata
);
    import sbi_pkg::*;

    localparam int TOTAL = MAX_PIXELS + PIPE_DEPTH;
    localparam int CNT_W = $clog2(TOTAL + 1);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]  mode_reg;
    logic [6:0]  len_reg;
    logic [15:0] inject_reg, amount_reg;
    logic [16:0] dt_reg;
    logic [34:0] rd_reg;
    logic [38:0] k_reg;
    logic [23:0] f_reg;
    logic [15:0] prior_reg;

    logic        take_in, run, en, feed, last_shift;
    logic [6:0]  n_act;
    logic [2:0]  mode_eff;
    logic [17:0] rate;
    logic [5:0]  idx;
    logic [15:0] level [0:MAX_PIXELS-1];
    logic [15:0] wb_level;
    pix_tag_t    tag_in, tag_out;
    logic [15:0] right_in, left_in;

    logic        m_valid_reg;
    logic [23:0] m_data_reg;
    logic        m_last_reg;

    always_comb begin
        n_act = len_reg;
        if (len_reg < 7'd3) begin
            n_act = 7'd3;
        end else if (len_reg > 7'(MAX_PIXELS)) begin
            n_act = 7'(MAX_PIXELS);
        end
        mode_eff = (mode_reg > MODE_BOTH) ? MODE_PLAIN : mode_reg;
        case (mode_eff)
            MODE_PLAIN: rate = 18'(amount_reg) + RATE_OFFSET;
            MODE_START,
            MODE_END:   rate = HALF_Q16 + 18'(amount_reg) * 18'd3 + RATE_OFFSET;
            default:    rate = HALF_Q16 + {1'b0, amount_reg, 1'b0} + RATE_OFFSET;
        endcase
    end

    assign en         = !(m_valid_reg && !m_tready);
    assign last_shift = (cnt_reg == CNT_W'(TOTAL - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_PREP;
            ST_PREP:  state_next = ST_SETUP;
            ST_SETUP: state_next = ST_RUN;
            ST_RUN:   if (en && last_shift) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        run      = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_RUN:  run = 1'b1;
            default: ;
        endcase
    end

    assign take_in  = s_tvalid && s_tready;
    assign feed     = run && (cnt_reg < CNT_W'(MAX_PIXELS));
    assign idx      = cnt_reg[5:0];
    assign cnt_next = (run && en) ? cnt_reg + CNT_W'(1) : (run ? cnt_reg : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            mode_reg  <= MODE_PLAIN;
            len_reg   <= 7'd64;
            prior_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_wen && cfg_addr == REG_BLUR_MODE) begin
                mode_reg <= cfg_wdata[2:0];
            end
            if (cfg_wen && cfg_addr == REG_STRIP_LENGTH) begin
                len_reg <= cfg_wdata;
            end
            if (feed && en) begin
                prior_reg <= level[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            inject_reg <= s_tdata[15:0];
            amount_reg <= s_tdata[31:16];
            dt_reg     <= (s_tdata[48:32] > DT_MAX) ? DT_MAX : s_tdata[48:32];
        end
        if (state_reg == ST_PREP) begin
            rd_reg <= 35'(rate) * 35'(dt_reg);
            f_reg  <= FADE_DIV - 24'(dt_reg);
        end
        if (state_reg == ST_SETUP) begin
            k_reg <= {rd_reg, 4'd0} - 39'(rd_reg);
        end
    end

    // ring of cells, tail takes the pipe result
    for (genvar g = 0; g < MAX_PIXELS; g++) begin : g_cell
        logic [15:0] nb;
        if (g == MAX_PIXELS - 1) begin : g_tail
            assign nb = wb_level;
        end else begin : g_body
            assign nb = level[g+1];
        end
        sbi_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (run && en),
            .level_in  (nb),
            .level_out (level[g])
        );
    end

    always_comb begin
        left_in  = (idx == 6'd0) ? level[0] : prior_reg;
        right_in = (7'(idx) + 7'd1 >= n_act) ? level[0] : level[1];
        tag_in.valid  = feed;
        tag_in.emit   = feed && (7'(idx) < n_act);
        tag_in.last   = (7'(idx) + 7'd1 == n_act);
        tag_in.keep   = (7'(idx) >= n_act);
        tag_in.idx    = idx;
        tag_in.centre = level[0];
        tag_in.inj    = ((mode_eff == MODE_START || mode_eff == MODE_BOTH) && idx == 6'd0)
                     || ((mode_eff == MODE_END || mode_eff == MODE_BOTH)
                         && 7'(idx) + 7'd1 == n_act)
                     || (mode_eff == MODE_MID && 7'(idx) == (n_act >> 1));
    end

    sbi_pipe u_pipe (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .tag_in       (tag_in),
        .left         (left_in),
        .right        (right_in),
        .k_factor     (k_reg),
        .fade_factor  (f_reg),
        .inject_level (inject_reg),
        .tag_out      (tag_out),
        .level_out    (wb_level)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= tag_out.valid && tag_out.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {2'b00, wb_level, tag_out.idx};
            m_last_reg <= tag_out.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !tag_out.valid)
        else $error("pipe holds a pixel while idle");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (7'(m_data_reg[5:0]) + 7'd1 == n_act))
        else $error("tlast on wrong pixel");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (cnt_reg < CNT_W'(TOTAL)))
        else $error("frame counter overrun");

endmodule
